// File: design/alcs_pkg.sv
`timescale 1ns / 1ps

package alcs_pkg;

    // Field widths of the poll and result channels.
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int BUTTON_W  = 3;
    localparam int VIEW_W    = 2;
    localparam int CURSOR_W  = 2;
    localparam int HT_W      = 2;
    localparam int HU_W      = 4;
    localparam int MT_W      = 3;
    localparam int MU_W      = 4;

    // Largest legal readings from the real-time clock.
    localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;

    // Upper limit of each edit digit for 24-hour HH:MM.
    localparam logic [HT_W-1:0] HT_MAX = 2'd2;
    localparam logic [HU_W-1:0] HU_MAX = 4'd9;
    localparam logic [MT_W-1:0] MT_MAX = 3'd5;
    localparam logic [MU_W-1:0] MU_MAX = 4'd9;

    // Highest hour units digit allowed when the hour tens digit is 2.
    localparam logic [HU_W-1:0] HU_MAX_LATE = 4'd3;

    // Cursor positions.
    localparam logic [CURSOR_W-1:0] CUR_HOUR_TENS   = 2'd0;
    localparam logic [CURSOR_W-1:0] CUR_HOUR_UNITS  = 2'd1;
    localparam logic [CURSOR_W-1:0] CUR_MINUTE_TENS = 2'd2;
    localparam logic [CURSOR_W-1:0] CUR_MINUTE_UNITS = 2'd3;

    typedef enum logic [BUTTON_W-1:0] {
        KEY_NONE    = 3'd0,
        KEY_UP      = 3'd1,
        KEY_DOWN    = 3'd2,
        KEY_LEFT    = 3'd3,
        KEY_RIGHT   = 3'd4,
        KEY_CONTROL = 3'd5
    } t_button;

    typedef enum logic [VIEW_W-1:0] {
        VIEW_CLOCK     = 2'd0,
        VIEW_SET_TIME  = 2'd1,
        VIEW_SET_ALARM = 2'd2
    } t_view;

    typedef struct packed {
        logic [MT_W-1:0] tens;
        logic [MU_W-1:0] units;
    } t_bcd2;

    typedef struct packed {
        logic [VIEW_W-1:0]   view_mode;
        logic                editing;
        logic [CURSOR_W-1:0] cursor;
        logic [HT_W-1:0]     digit_hour_tens;
        logic [HU_W-1:0]     digit_hour_units;
        logic [MT_W-1:0]     digit_minute_tens;
        logic [MU_W-1:0]     digit_minute_units;
        logic                alarm_armed;
        logic                ringing;
        logic                button_accepted;
        logic                rtc_write;
        logic                refresh;
    } t_result;

    // Split a value below 60 into two BCD digits with a compare chain.
    function automatic t_bcd2 bin_to_bcd(input logic [MINUTE_W-1:0] v);
        t_bcd2               r;
        logic [MINUTE_W-1:0] t6;
        logic [MINUTE_W-1:0] diff;
        if (v >= 6'd50) begin
            r.tens = 3'd5;
        end else if (v >= 6'd40) begin
            r.tens = 3'd4;
        end else if (v >= 6'd30) begin
            r.tens = 3'd3;
        end else if (v >= 6'd20) begin
            r.tens = 3'd2;
        end else if (v >= 6'd10) begin
            r.tens = 3'd1;
        end else begin
            r.tens = 3'd0;
        end
        t6 = {3'b000, r.tens};
        diff = v - ((t6 << 3) + (t6 << 1));
        r.units = diff[MU_W-1:0];
        return r;
    endfunction

    // Join two BCD digits into a binary value: tens * 8 + tens * 2 + units.
    function automatic logic [MINUTE_W-1:0] bcd_to_bin(input logic [MT_W-1:0] tens,
                                                      input logic [MU_W-1:0] units);
        logic [MINUTE_W-1:0] t6;
        t6 = {3'b000, tens};
        return (t6 << 3) + (t6 << 1) + {2'b00, units};
    endfunction

endpackage

// File: design/alcs_poll_if.sv
`timescale 1ns / 1ps

interface alcs_poll_if;
    logic                           valid;
    logic                           ready;
    logic [alcs_pkg::HOUR_W-1:0]    rtc_hours;
    logic [alcs_pkg::MINUTE_W-1:0]  rtc_minutes;
    logic [alcs_pkg::BUTTON_W-1:0]  button;

    modport source (output valid, rtc_hours, rtc_minutes, button, input ready);
    modport sink   (input valid, rtc_hours, rtc_minutes, button, output ready);
endinterface

// File: design/alcs_result_if.sv
`timescale 1ns / 1ps

interface alcs_result_if;
    logic                           valid;
    logic                           ready;
    logic [alcs_pkg::VIEW_W-1:0]    view_mode;
    logic                           editing;
    logic [alcs_pkg::CURSOR_W-1:0]  cursor;
    logic [alcs_pkg::HT_W-1:0]      digit_hour_tens;
    logic [alcs_pkg::HU_W-1:0]      digit_hour_units;
    logic [alcs_pkg::MT_W-1:0]      digit_minute_tens;
    logic [alcs_pkg::MU_W-1:0]      digit_minute_units;
    logic                           alarm_armed;
    logic                           ringing;
    logic                           button_accepted;
    logic                           rtc_write;
    logic                           refresh;

    modport source (
        output valid, view_mode, editing, cursor, digit_hour_tens, digit_hour_units,
               digit_minute_tens, digit_minute_units, alarm_armed, ringing,
               button_accepted, rtc_write, refresh,
        input  ready
    );
    modport sink (
        input  valid, view_mode, editing, cursor, digit_hour_tens, digit_hour_units,
               digit_minute_tens, digit_minute_units, alarm_armed, ringing,
               button_accepted, rtc_write, refresh,
        output ready
    );
endinterface

// File: design/alcs_in_reg.sv
`timescale 1ns / 1ps

module alcs_in_reg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    alcs_poll_if.sink   i_poll,
    alcs_poll_if.source o_poll
);

    logic                          r_valid;
    logic [alcs_pkg::HOUR_W-1:0]   r_hours;
    logic [alcs_pkg::MINUTE_W-1:0] r_minutes;
    logic [alcs_pkg::BUTTON_W-1:0] r_button;
    logic [alcs_pkg::HOUR_W-1:0]   n_hours;
    logic [alcs_pkg::MINUTE_W-1:0] n_minutes;
    logic [alcs_pkg::BUTTON_W-1:0] n_button;
    logic                          take;

    // The register refills whenever it is empty or its item moves on.
    assign i_poll.ready = !r_valid || o_poll.ready;
    assign take         = i_poll.valid && i_poll.ready;

    // Clamp out-of-range clock readings and map unknown button codes to none.
    always_comb begin
        n_hours   = (i_poll.rtc_hours > alcs_pkg::HOUR_MAX) ? alcs_pkg::HOUR_MAX
                                                             : i_poll.rtc_hours;
        n_minutes = (i_poll.rtc_minutes > alcs_pkg::MINUTE_MAX) ? alcs_pkg::MINUTE_MAX
                                                                 : i_poll.rtc_minutes;
        n_button  = (i_poll.button > alcs_pkg::KEY_CONTROL) ? alcs_pkg::KEY_NONE
                                                             : i_poll.button;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_poll.ready) begin
            r_valid <= i_poll.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_hours   <= n_hours;
            r_minutes <= n_minutes;
            r_button  <= n_button;
        end
    end

    assign o_poll.valid       = r_valid;
    assign o_poll.rtc_hours   = r_hours;
    assign o_poll.rtc_minutes = r_minutes;
    assign o_poll.button      = r_button;

endmodule

// File: design/alcs_engine.sv
`timescale 1ns / 1ps

module alcs_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    alcs_poll_if.sink     i_poll,
    alcs_result_if.source o_result
);

    // Controller state.
    logic [alcs_pkg::HOUR_W-1:0]   r_clk_h,  n_clk_h;
    logic [alcs_pkg::MINUTE_W-1:0] r_clk_m,  n_clk_m;
    logic                          r_known,  n_known;
    logic [alcs_pkg::HOUR_W-1:0]   r_alm_h,  n_alm_h;
    logic [alcs_pkg::MINUTE_W-1:0] r_alm_m,  n_alm_m;
    logic                          r_armed,  n_armed;
    logic                          r_ring,   n_ring;
    alcs_pkg::t_view               r_view,   n_view;
    logic                          r_edit,   n_edit;
    logic [alcs_pkg::CURSOR_W-1:0] r_cursor, n_cursor;
    logic [alcs_pkg::HT_W-1:0]     r_dig0,   n_dig0;
    logic [alcs_pkg::HU_W-1:0]     r_dig1,   n_dig1;
    logic [alcs_pkg::MT_W-1:0]     r_dig2,   n_dig2;
    logic [alcs_pkg::MU_W-1:0]     r_dig3,   n_dig3;

    // Result register.
    logic                          r_res_valid;
    alcs_pkg::t_result             r_res, n_res;

    logic                          advance;
    logic                          changed;
    logic                          accepted;
    logic                          wrote;
    alcs_pkg::t_button             btn;
    logic [alcs_pkg::MINUTE_W-1:0] edit_h6;
    logic [alcs_pkg::MINUTE_W-1:0] edit_m6;
    alcs_pkg::t_bcd2               load_h;
    alcs_pkg::t_bcd2               load_m;
    alcs_pkg::t_bcd2               show_h;
    alcs_pkg::t_bcd2               show_m;

    // A poll is processed when the result register is free or being drained.
    assign i_poll.ready = !r_res_valid || o_result.ready;
    assign advance      = i_poll.valid && i_poll.ready;
    assign btn          = alcs_pkg::t_button'(i_poll.button);

    // Edit digits as binary time, for commit and compare.
    assign edit_h6 = alcs_pkg::bcd_to_bin({1'b0, r_dig0}, r_dig1);
    assign edit_m6 = alcs_pkg::bcd_to_bin(r_dig2, r_dig3);

    // Next state: take the clock reading, handle the button, test the alarm.
    always_comb begin
        n_clk_h  = r_clk_h;
        n_clk_m  = r_clk_m;
        n_known  = r_known;
        n_alm_h  = r_alm_h;
        n_alm_m  = r_alm_m;
        n_armed  = r_armed;
        n_ring   = r_ring;
        n_view   = r_view;
        n_edit   = r_edit;
        n_cursor = r_cursor;
        n_dig0   = r_dig0;
        n_dig1   = r_dig1;
        n_dig2   = r_dig2;
        n_dig3   = r_dig3;
        accepted = 1'b0;
        wrote    = 1'b0;

        changed = !r_known || (i_poll.rtc_hours != r_clk_h)
                  || (i_poll.rtc_minutes != r_clk_m);
        if (changed) begin
            n_clk_h = i_poll.rtc_hours;
            n_clk_m = i_poll.rtc_minutes;
            n_known = 1'b1;
        end

        load_h = alcs_pkg::bin_to_bcd({1'b0, n_clk_h});
        load_m = alcs_pkg::bin_to_bcd(n_clk_m);
        if (r_view == alcs_pkg::VIEW_SET_ALARM) begin
            load_h = alcs_pkg::bin_to_bcd({1'b0, r_alm_h});
            load_m = alcs_pkg::bin_to_bcd(r_alm_m);
        end

        if (btn != alcs_pkg::KEY_NONE) begin
            if (r_ring) begin
                // Any button silences a ringing alarm and arms it again.
                n_ring  = 1'b0;
                n_armed = 1'b1;
            end else if (r_edit) begin
                accepted = 1'b1;
                unique case (btn)
                    alcs_pkg::KEY_RIGHT: begin
                        n_cursor = r_cursor + 2'd1;
                    end
                    alcs_pkg::KEY_LEFT: begin
                        n_cursor = r_cursor - 2'd1;
                    end
                    alcs_pkg::KEY_UP: begin
                        unique case (r_cursor)
                            alcs_pkg::CUR_HOUR_TENS: begin
                                if (r_dig0 == 2'd1 && r_dig1 > alcs_pkg::HU_MAX_LATE) begin
                                    n_dig0 = alcs_pkg::HT_MAX;
                                    n_dig1 = alcs_pkg::HU_MAX_LATE;
                                end else begin
                                    n_dig0 = (r_dig0 == alcs_pkg::HT_MAX) ? 2'd0
                                                                          : r_dig0 + 2'd1;
                                end
                            end
                            alcs_pkg::CUR_HOUR_UNITS: begin
                                if (r_dig0 == alcs_pkg::HT_MAX) begin
                                    n_dig1 = (r_dig1 + 4'd1) & 4'd3;
                                end else begin
                                    n_dig1 = (r_dig1 == alcs_pkg::HU_MAX) ? 4'd0
                                                                          : r_dig1 + 4'd1;
                                end
                            end
                            alcs_pkg::CUR_MINUTE_TENS: begin
                                n_dig2 = (r_dig2 == alcs_pkg::MT_MAX) ? 3'd0 : r_dig2 + 3'd1;
                            end
                            alcs_pkg::CUR_MINUTE_UNITS: begin
                                n_dig3 = (r_dig3 == alcs_pkg::MU_MAX) ? 4'd0 : r_dig3 + 4'd1;
                            end
                        endcase
                    end
                    alcs_pkg::KEY_DOWN: begin
                        unique case (r_cursor)
                            alcs_pkg::CUR_HOUR_TENS: begin
                                if (r_dig0 == 2'd0) begin
                                    n_dig0 = alcs_pkg::HT_MAX;
                                    if (r_dig1 > alcs_pkg::HU_MAX_LATE) begin
                                        n_dig1 = alcs_pkg::HU_MAX_LATE;
                                    end
                                end else begin
                                    n_dig0 = r_dig0 - 2'd1;
                                end
                            end
                            alcs_pkg::CUR_HOUR_UNITS: begin
                                if (r_dig0 == alcs_pkg::HT_MAX && r_dig1 == 4'd0) begin
                                    n_dig1 = alcs_pkg::HU_MAX_LATE;
                                end else if (r_dig1 == 4'd0) begin
                                    n_dig1 = alcs_pkg::HU_MAX;
                                end else begin
                                    n_dig1 = r_dig1 - 4'd1;
                                end
                            end
                            alcs_pkg::CUR_MINUTE_TENS: begin
                                n_dig2 = (r_dig2 == 3'd0) ? alcs_pkg::MT_MAX : r_dig2 - 3'd1;
                            end
                            alcs_pkg::CUR_MINUTE_UNITS: begin
                                n_dig3 = (r_dig3 == 4'd0) ? alcs_pkg::MU_MAX : r_dig3 - 4'd1;
                            end
                        endcase
                    end
                    alcs_pkg::KEY_CONTROL: begin
                        // Commit the edit to the alarm or to the clock.
                        if (r_view == alcs_pkg::VIEW_SET_ALARM) begin
                            if (edit_h6[alcs_pkg::HOUR_W-1:0] == r_alm_h
                                && edit_m6 == r_alm_m) begin
                                n_armed = !r_armed;
                            end else begin
                                n_alm_h = edit_h6[alcs_pkg::HOUR_W-1:0];
                                n_alm_m = edit_m6;
                                n_armed = 1'b1;
                            end
                        end else if (r_view == alcs_pkg::VIEW_SET_TIME) begin
                            n_clk_h = edit_h6[alcs_pkg::HOUR_W-1:0];
                            n_clk_m = edit_m6;
                            wrote   = 1'b1;
                        end
                        n_edit = 1'b0;
                    end
                    default: begin
                        accepted = 1'b0;
                    end
                endcase
            end else begin
                // Navigation between views, or the start of an edit.
                priority if (btn == alcs_pkg::KEY_DOWN) begin
                    accepted = 1'b1;
                    unique case (r_view)
                        alcs_pkg::VIEW_CLOCK:     n_view = alcs_pkg::VIEW_SET_TIME;
                        alcs_pkg::VIEW_SET_TIME:  n_view = alcs_pkg::VIEW_SET_ALARM;
                        alcs_pkg::VIEW_SET_ALARM: n_view = alcs_pkg::VIEW_CLOCK;
                        default:                  n_view = alcs_pkg::VIEW_SET_TIME;
                    endcase
                end else if (btn == alcs_pkg::KEY_UP) begin
                    accepted = 1'b1;
                    unique case (r_view)
                        alcs_pkg::VIEW_CLOCK:     n_view = alcs_pkg::VIEW_SET_ALARM;
                        alcs_pkg::VIEW_SET_TIME:  n_view = alcs_pkg::VIEW_CLOCK;
                        alcs_pkg::VIEW_SET_ALARM: n_view = alcs_pkg::VIEW_SET_TIME;
                        default:                  n_view = alcs_pkg::VIEW_SET_ALARM;
                    endcase
                end else if (btn == alcs_pkg::KEY_CONTROL && r_view != alcs_pkg::VIEW_CLOCK) begin
                    accepted = 1'b1;
                    n_edit   = 1'b1;
                    n_cursor = alcs_pkg::CUR_HOUR_TENS;
                    n_dig0   = load_h.tens[alcs_pkg::HT_W-1:0];
                    n_dig1   = load_h.units;
                    n_dig2   = load_m.tens;
                    n_dig3   = load_m.units;
                end else begin
                    accepted = 1'b0;
                end
            end
        end

        // A new minute that meets an armed alarm starts it ringing.
        if (changed && n_armed && n_clk_h == n_alm_h && n_clk_m == n_alm_m) begin
            n_ring  = 1'b1;
            n_armed = 1'b0;
        end
    end

    // Result fields from the updated state.
    always_comb begin
        show_h = alcs_pkg::bin_to_bcd({1'b0, n_clk_h});
        show_m = alcs_pkg::bin_to_bcd(n_clk_m);
        if (n_view == alcs_pkg::VIEW_SET_ALARM) begin
            show_h = alcs_pkg::bin_to_bcd({1'b0, n_alm_h});
            show_m = alcs_pkg::bin_to_bcd(n_alm_m);
        end

        n_res.view_mode       = n_view;
        n_res.editing         = n_edit;
        n_res.cursor          = n_edit ? n_cursor : alcs_pkg::CUR_HOUR_TENS;
        n_res.alarm_armed     = n_armed;
        n_res.ringing         = n_ring;
        n_res.button_accepted = accepted;
        n_res.rtc_write       = wrote;
        n_res.refresh         = changed || (btn != alcs_pkg::KEY_NONE);
        if (n_edit) begin
            n_res.digit_hour_tens    = n_dig0;
            n_res.digit_hour_units   = n_dig1;
            n_res.digit_minute_tens  = n_dig2;
            n_res.digit_minute_units = n_dig3;
        end else begin
            n_res.digit_hour_tens    = show_h.tens[alcs_pkg::HT_W-1:0];
            n_res.digit_hour_units   = show_h.units;
            n_res.digit_minute_tens  = show_m.tens;
            n_res.digit_minute_units = show_m.units;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_h  <= '0;
            r_clk_m  <= '0;
            r_known  <= 1'b0;
            r_alm_h  <= '0;
            r_alm_m  <= '0;
            r_armed  <= 1'b0;
            r_ring   <= 1'b0;
            r_view   <= alcs_pkg::VIEW_CLOCK;
            r_edit   <= 1'b0;
            r_cursor <= alcs_pkg::CUR_HOUR_TENS;
            r_dig0   <= '0;
            r_dig1   <= '0;
            r_dig2   <= '0;
            r_dig3   <= '0;
        end else if (advance) begin
            r_clk_h  <= n_clk_h;
            r_clk_m  <= n_clk_m;
            r_known  <= n_known;
            r_alm_h  <= n_alm_h;
            r_alm_m  <= n_alm_m;
            r_armed  <= n_armed;
            r_ring   <= n_ring;
            r_view   <= n_view;
            r_edit   <= n_edit;
            r_cursor <= n_cursor;
            r_dig0   <= n_dig0;
            r_dig1   <= n_dig1;
            r_dig2   <= n_dig2;
            r_dig3   <= n_dig3;
        end
    end

    // Result register: holds its item until the receiver takes the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_poll.ready) begin
            r_res_valid <= i_poll.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid              = r_res_valid;
    assign o_result.view_mode          = r_res.view_mode;
    assign o_result.editing            = r_res.editing;
    assign o_result.cursor             = r_res.cursor;
    assign o_result.digit_hour_tens    = r_res.digit_hour_tens;
    assign o_result.digit_hour_units   = r_res.digit_hour_units;
    assign o_result.digit_minute_tens  = r_res.digit_minute_tens;
    assign o_result.digit_minute_units = r_res.digit_minute_units;
    assign o_result.alarm_armed        = r_res.alarm_armed;
    assign o_result.ringing            = r_res.ringing;
    assign o_result.button_accepted    = r_res.button_accepted;
    assign o_result.rtc_write          = r_res.rtc_write;
    assign o_result.refresh            = r_res.refresh;

endmodule

// File: design/alarm_clock_set_controller.sv
`timescale 1ns / 1ps

// Alarm clock set controller, 24-hour HH:MM.
// i_poll carries one poll per transfer: the hour and minute read from the
// real-time clock and a button code. o_result carries one result per poll:
// view mode, edit flag and cursor, the four shown digits, the armed and
// ringing flags, and the button_accepted, rtc_write and refresh strobes.
// Two register stages, the input register and the result register; a poll
// moves from the input register through the state update into the result
// register, and its result is offered on o_result from there.
// Throughput: one poll per cycle while the receiver takes each result, set
// by the state update between the input register and the result register.
// Reset (i_rst_n low at a clock edge) empties both registers and returns the
// controller to clock view, alarm 00:00 disarmed, nothing ringing, and an
// unknown clock time, so the first poll always counts as a new minute.
// When the receiver stalls, the result register holds its item, one more
// poll waits in the input register, and i_poll.ready then drops until the
// result transfer takes place. Nothing is lost or repeated.
module alarm_clock_set_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    alcs_poll_if.sink     i_poll,
    alcs_result_if.source o_result
);

    alcs_poll_if u_clamped ();

    alcs_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_poll  (i_poll),
        .o_poll  (u_clamped.source)
    );

    alcs_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_poll   (u_clamped.sink),
        .o_result (o_result)
    );

endmodule
